// ----- hdl/fragmented_register_transaction_tracker_unit_defines.svh -----
// Assertion macros used by the tracker controller
`ifndef FRAGMENTED_REGISTER_TRANSACTION_TRACKER_UNIT_DEFINES_SVH
`define FRAGMENTED_REGISTER_TRANSACTION_TRACKER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FRTT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define FRTT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");

`endif

// ----- hdl/frtt_pkg.sv -----
package frtt_pkg;

    localparam int WINDOW_REGS_DEF = 32;
    localparam int FRAME_REGS_DEF  = 4;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // input function codes
    localparam logic [2:0] FN_RD    = 3'd0;
    localparam logic [2:0] FN_WR    = 3'd1;
    localparam logic [2:0] FN_FRAG  = 3'd2;
    localparam logic [2:0] FN_TICK  = 3'd3;
    localparam logic [2:0] FN_ABORT = 3'd4;

    // fragment kinds
    localparam logic [1:0] FK_DATA = 2'd0;
    localparam logic [1:0] FK_ACK  = 2'd1;
    localparam logic [1:0] FK_NACK = 2'd2;

    // result status codes
    localparam logic [3:0] ST_STARTED   = 4'd0;
    localparam logic [3:0] ST_REJECTED  = 4'd1;
    localparam logic [3:0] ST_PARTIAL   = 4'd2;
    localparam logic [3:0] ST_MISMATCH  = 4'd3;
    localparam logic [3:0] ST_RD_DONE   = 4'd4;
    localparam logic [3:0] ST_WR_DONE   = 4'd5;
    localparam logic [3:0] ST_REFUSED   = 4'd6;
    localparam logic [3:0] ST_TICK_Q    = 4'd7;
    localparam logic [3:0] ST_TICK_ACT  = 4'd8;
    localparam logic [3:0] ST_ABANDONED = 4'd9;
    localparam logic [3:0] ST_ABAND_IGN = 4'd10;

    // register addresses
    localparam logic [1:0] REG_TIMEOUT = 2'd0;

    // controller to datapath
    typedef struct packed {
        logic eval;    // latch decision of the held transaction
        logic commit;  // apply state update and write fragment words
        logic dump;    // start emitting the window
        logic step;    // advance the emit position
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic valid_func; // transaction produces results
        logic complete;   // window complete after commit
        logic last_word;  // emit position is at the final word
    } t_sts;

endpackage

// ----- hdl/frtt_datapath.sv -----
module frtt_datapath #(
    parameter int WINDOW_REGS = 32,
    parameter int FRAME_REGS  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [2:0]         i_func,
    input  logic [7:0]         i_page,
    input  logic [7:0]         i_offset,
    input  logic [7:0]         i_count,
    input  logic [1:0]         i_frag_op,
    input  logic [15:0]        i_word_a,
    input  logic [15:0]        i_word_b,
    input  logic [15:0]        i_word_c,
    input  logic [15:0]        i_word_d,
    input  logic [15:0]        i_timeout,
    input  frtt_pkg::t_cmd     i_cmd,
    output frtt_pkg::t_sts     o_sts,
    output logic [3:0]         o_status,
    output logic [7:0]         o_word_index,
    output logic [15:0]        o_word_value,
    output logic               o_last,
    output logic               o_busy_res,
    output logic               o_link_down,
    output logic               o_request_dropped,
    output logic [15:0]        o_mismatch_total,
    output logic [15:0]        o_timeout_total,
    output logic [15:0]        o_refusal_total,
    output logic [15:0]        o_reply_total,
    output logic [15:0]        o_request_total
);
    import frtt_pkg::*;

    localparam int PB = 5;

    // held transaction
    logic [2:0]  r_func;
    logic [7:0]  r_page, r_off, r_cnt;
    logic [1:0]  r_kind;
    logic [15:0] r_w [4];

    // tracker state
    logic        r_pend, r_wr, r_down;
    logic [7:0]  r_wpage;
    logic [4:0]  r_woff;
    logic [5:0]  r_wcnt;
    logic [31:0] r_seen;
    logic [15:0] r_rage, r_page_age;
    logic [15:0] r_cnt_mm, r_cnt_to, r_cnt_rf, r_cnt_rp, r_cnt_rq;
    logic [15:0] r_mem [32];

    // decision registers (eval stage)
    logic [3:0]  r_st;
    logic        r_ok, r_fin, r_refuse, r_tick_drop, r_tick_down, r_frag_ok;
    logic [4:0]  r_at;

    // emit position
    logic [PB-1:0] r_pos;
    logic [15:0]   r_rd;

    function automatic logic [15:0] sat(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // evaluation combinational
    logic [8:0]  c_wend, c_fend;
    logic        c_start_ok, c_isd, c_isa, c_isn, c_ours, c_fok, c_mis;
    logic [15:0] c_rage, c_pyage;
    logic [7:0]  c_rel;
    always_comb begin
        c_wend     = {4'd0, r_woff} + {3'd0, r_wcnt};
        c_fend     = {1'b0, r_off} + {1'b0, r_cnt};
        c_start_ok = !r_pend && r_cnt != 8'd0 && r_cnt <= 8'(WINDOW_REGS)
                     && c_fend <= 9'(WINDOW_REGS);
        c_isd = r_kind == FK_DATA && !r_wr;
        c_isa = r_kind == FK_ACK && r_wr;
        c_isn = r_kind == FK_NACK;
        c_rel = r_off - {3'd0, r_woff};
        if (!r_wr) c_ours = r_off == {3'd0, r_woff};
        else if (r_off < {3'd0, r_woff} || {1'b0, r_off} >= c_wend) c_ours = 1'b0;
        else begin
            // frame start: offset into the window is a multiple of the frame size
            c_ours = 1'b0;
            for (int k = 0; k < 32; k++)
                if (c_rel == 8'(k * FRAME_REGS)) c_ours = 1'b1;
        end
        c_fok = r_cnt != 8'd0 && r_cnt <= 8'(FRAME_REGS) && r_off >= {3'd0, r_woff}
                && c_fend <= c_wend;
        c_mis = !r_pend || !(c_isd || c_isa || c_isn) || r_page != r_wpage
                || (c_isn ? !c_ours : !c_fok);
        c_rage  = sat(r_rage);
        c_pyage = sat(r_page_age);
    end

    // fragment write mask and completion
    logic [31:0] c_new, c_want;
    always_comb begin
        c_new = r_seen;
        for (int i = 0; i < FRAME_REGS; i++)
            if (i < int'(r_cnt)) c_new[5'(r_at + 5'(i))] = 1'b1;
        c_want = (r_wcnt >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << r_wcnt) - 32'd1);
    end

    assign o_sts.valid_func = r_func <= FN_ABORT;
    assign o_sts.complete   = r_func == FN_FRAG && r_frag_ok && !r_refuse
                              && (c_new & c_want) == c_want;
    assign o_sts.last_word  = {1'b0, r_pos} + 6'd1 == r_wcnt;

    // load and evaluate
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func <= i_func; r_page <= i_page; r_off <= i_offset;
            r_cnt <= i_count; r_kind <= i_frag_op;
            r_w[0] <= i_word_a; r_w[1] <= i_word_b;
            r_w[2] <= i_word_c; r_w[3] <= i_word_d;
        end
        if (i_cmd.eval) begin
            r_at        <= c_rel[4:0];
            r_ok        <= c_start_ok;
            r_frag_ok   <= !c_mis;
            r_refuse    <= c_isn;
            r_tick_drop <= r_pend && c_rage >= i_timeout;
            r_tick_down <= !r_down && c_pyage >= i_timeout;
        end
    end

    // commit state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0; r_wr <= 1'b0; r_wpage <= '0; r_woff <= '0;
            r_wcnt <= '0; r_seen <= '0; r_rage <= '0; r_page_age <= '0;
            r_down <= 1'b0; r_cnt_mm <= '0; r_cnt_to <= '0; r_cnt_rf <= '0;
            r_cnt_rp <= '0; r_cnt_rq <= '0; r_st <= ST_STARTED;
            r_fin <= 1'b0; r_pos <= '0;
            o_request_dropped <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                o_request_dropped <= 1'b0;
                r_fin <= 1'b0;
                case (r_func)
                    FN_RD, FN_WR: begin
                        if (r_ok) begin
                            r_pend <= 1'b1; r_wr <= r_func == FN_WR;
                            r_wpage <= r_page; r_woff <= r_off[4:0];
                            r_wcnt <= r_cnt[5:0]; r_seen <= '0; r_rage <= '0;
                            r_cnt_rq <= sat(r_cnt_rq); r_st <= ST_STARTED;
                        end else r_st <= ST_REJECTED;
                    end
                    FN_FRAG: begin
                        if (!r_frag_ok) begin
                            r_cnt_mm <= sat(r_cnt_mm); r_st <= ST_MISMATCH;
                        end else if (r_refuse || o_sts.complete) begin
                            r_pend <= 1'b0; r_page_age <= '0; r_down <= 1'b0;
                            r_cnt_rp <= sat(r_cnt_rp);
                            if (r_refuse) begin
                                r_cnt_rf <= sat(r_cnt_rf); r_st <= ST_REFUSED;
                            end else begin
                                r_seen <= c_new; r_fin <= 1'b1;
                                r_st <= r_wr ? ST_WR_DONE : ST_RD_DONE;
                            end
                        end else begin
                            r_seen <= c_new; r_st <= ST_PARTIAL;
                        end
                    end
                    FN_TICK: begin
                        r_rage <= c_rage; r_page_age <= c_pyage;
                        if (r_tick_drop) begin
                            r_pend <= 1'b0; r_cnt_to <= sat(r_cnt_to);
                            o_request_dropped <= 1'b1;
                        end
                        if (r_tick_down) r_down <= 1'b1;
                        r_st <= (r_tick_drop || r_tick_down) ? ST_TICK_ACT : ST_TICK_Q;
                    end
                    FN_ABORT: begin
                        if (r_pend) begin
                            r_pend <= 1'b0; r_cnt_to <= sat(r_cnt_to);
                            r_st <= ST_ABANDONED;
                        end else r_st <= ST_ABAND_IGN;
                    end
                    default: r_st <= r_st;
                endcase
            end
            if (i_cmd.dump) r_pos <= '0;
            else if (i_cmd.step) r_pos <= r_pos + 5'd1;
        end
    end

    // word store: one fragment word per lane, lanes past the fourth store zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_func == FN_FRAG && r_frag_ok && !r_refuse)
            for (int i = 0; i < FRAME_REGS; i++)
                if (i < int'(r_cnt))
                    r_mem[5'(r_at + 5'(i))] <= (i < 4) ? r_w[2'(i)] : 16'd0;
        r_rd <= r_mem[i_cmd.dump ? 5'd0 : (i_cmd.step ? r_pos + 5'd1 : r_pos)];
    end

    // result fields
    always_comb begin
        o_status     = r_st;
        o_word_index = 8'd0;
        o_word_value = 16'd0;
        o_last       = 1'b1;
        if (r_fin) begin
            o_word_index = {3'd0, r_pos};
            o_word_value = r_rd;
            o_last       = o_sts.last_word;
        end else if (r_st == ST_REFUSED) begin
            o_word_index = r_off;
            o_word_value = r_w[0];
        end
    end
    assign o_busy_res       = r_pend;
    assign o_link_down      = r_down;
    assign o_mismatch_total = r_cnt_mm;
    assign o_timeout_total  = r_cnt_to;
    assign o_refusal_total  = r_cnt_rf;
    assign o_reply_total    = r_cnt_rp;
    assign o_request_total  = r_cnt_rq;
endmodule

// ----- hdl/frtt_ctrl.sv -----
module frtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_load,
    output frtt_pkg::t_cmd o_cmd,
    input  frtt_pkg::t_sts i_sts
);
    import frtt_pkg::*;
    `include "fragmented_register_transaction_tracker_unit_defines.svh"

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_COMMIT, S_FILL, S_OUT, S_STEP} t_state;
    t_state r_state;
    logic   r_dump;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_load      = i_in_valid && o_in_ready;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        o_cmd        = '0;
        o_cmd.eval   = r_state == S_EVAL;
        o_cmd.commit = r_state == S_COMMIT;
        o_cmd.dump   = r_state == S_FILL;
        o_cmd.step   = r_state == S_OUT && i_out_ready && r_dump && !i_sts.last_word;
    end

    // sequence: load, evaluate, commit, fill, present results; invalid functions return to idle after evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dump  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_EVAL;
                S_EVAL:   r_state <= i_sts.valid_func ? S_COMMIT : S_IDLE;
                S_COMMIT: begin
                    r_dump  <= i_sts.complete;
                    r_state <= S_FILL;
                end
                S_FILL:   r_state <= S_OUT;
                S_OUT: if (i_out_ready) begin
                    if (r_dump && !i_sts.last_word) r_state <= S_STEP;
                    else r_state <= S_IDLE;
                end
                S_STEP:   r_state <= S_OUT;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    `FRTT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `FRTT_ASSERT_NEXT(a_load_eval, i_clk, i_rst_n, o_load, r_state == S_EVAL)
    `FRTT_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.eval, o_cmd.commit, o_cmd.dump}))
endmodule

// ----- hdl/fragmented_register_transaction_tracker_unit.sv -----
// Channel | Direction | Handshake
// input   | in        | i_in_valid / o_in_ready, fields i_func .. i_word_d
// result  | out       | o_out_valid / i_out_ready, fields o_status .. o_request_total
// config  | in        | APB psel/penable/pwrite/paddr/pwdata, prdata, pready
// A transaction passes through the evaluate, commit and fill states before its result;
// a completed window presents each further word after a step state, once the last one is taken.
// One transaction is worked on at a time; input ready is low meanwhile.
// Reset is synchronous, active low, and clears state and counters.
// A stalled result holds until it is taken.
module fragmented_register_transaction_tracker_unit #(
    parameter int WINDOW_REGS = frtt_pkg::WINDOW_REGS_DEF,
    parameter int FRAME_REGS  = frtt_pkg::FRAME_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_page,
    input  logic [7:0]  i_offset,
    input  logic [7:0]  i_count,
    input  logic [1:0]  i_frag_op,
    input  logic [15:0] i_word_a,
    input  logic [15:0] i_word_b,
    input  logic [15:0] i_word_c,
    input  logic [15:0] i_word_d,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic [7:0]  o_word_index,
    output logic [15:0] o_word_value,
    output logic        o_last,
    output logic        o_busy_res,
    output logic        o_link_down,
    output logic        o_request_dropped,
    output logic [15:0] o_mismatch_total,
    output logic [15:0] o_timeout_total,
    output logic [15:0] o_refusal_total,
    output logic [15:0] o_reply_total,
    output logic [15:0] o_request_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import frtt_pkg::*;

    logic [15:0] r_timeout;
    logic        w_load;
    t_cmd        w_cmd;
    t_sts        w_sts;

    // timeout register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_timeout <= TIMEOUT_RESET;
        else if (psel && penable && pwrite && paddr == {REG_TIMEOUT})
            r_timeout <= pwdata[15:0];
    end
    assign prdata = (paddr == REG_TIMEOUT) ? {16'd0, r_timeout} : 32'd0;

    frtt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_load(w_load), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    frtt_datapath #(.WINDOW_REGS(WINDOW_REGS), .FRAME_REGS(FRAME_REGS)) u_dp (
        .i_clk, .i_rst_n, .i_load(w_load), .i_func, .i_page, .i_offset, .i_count,
        .i_frag_op, .i_word_a, .i_word_b, .i_word_c, .i_word_d,
        .i_timeout(r_timeout), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_status, .o_word_index, .o_word_value, .o_last, .o_busy_res,
        .o_link_down, .o_request_dropped, .o_mismatch_total, .o_timeout_total,
        .o_refusal_total, .o_reply_total, .o_request_total
    );
endmodule

// ----- test/fragmented_register_transaction_tracker_unit_tb.sv -----
module fragmented_register_transaction_tracker_unit_tb;
    import frtt_pkg::*;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  page;
        logic [7:0]  offset;
        logic [7:0]  count;
        logic [1:0]  frag_op;
        logic [15:0] wa, wb, wc, wd;
    } txn_t;

    typedef struct {
        logic [3:0]  status;
        logic [7:0]  idx;
        logic [15:0] value;
        logic        last, busy, down, dropped;
        logic [15:0] mism, tmo, refu, repl, reqs;
    } res_t;

    localparam int C_MISM = 0;
    localparam int C_TMO  = 1;
    localparam int C_REFU = 2;
    localparam int C_REPL = 3;
    localparam int C_REQS = 4;
    localparam logic [1:0] FK_OTHER = 2'd3;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [2:0]  i_func = 0;
    logic [7:0]  i_page = 0, i_offset = 0, i_count = 0;
    logic [1:0]  i_frag_op = 0;
    logic [15:0] i_word_a = 0, i_word_b = 0, i_word_c = 0, i_word_d = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [3:0]  o_status;
    logic [7:0]  o_word_index;
    logic [15:0] o_word_value;
    logic        o_last, o_busy_res, o_link_down, o_request_dropped;
    logic [15:0] o_mismatch_total, o_timeout_total, o_refusal_total;
    logic [15:0] o_reply_total, o_request_total;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    fragmented_register_transaction_tracker_unit uut (.*);

    // tracker shadow state
    logic        trk_pending, trk_write, trk_down;
    logic [7:0]  trk_page;
    logic [4:0]  trk_off;
    logic [5:0]  trk_cnt;
    logic [31:0] trk_seen;
    logic [15:0] trk_words [32];
    logic [15:0] req_age, rep_age, timeout_cfg;
    logic [15:0] totals [5];

    txn_t pending_txns[$];
    res_t expected_results[$];
    int   fails = 0;
    bit   run_en = 0;
    bit   calm = 0;
    bit   in_took = 0;
    int   send_gap = 0;
    int   ready_gap = 0;
    int   hold_cnt = 0;
    int   hold_token = 0, hold_seen = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic void bump(int which);
        if (totals[which] != 16'hFFFF) totals[which]++;
    endfunction

    function automatic void emit(logic [3:0] st, logic [7:0] idx, logic [15:0] val,
                                 logic last, logic dropped);
        res_t r;
        r.status = st; r.idx = idx; r.value = val; r.last = last;
        r.busy = trk_pending; r.down = trk_down; r.dropped = dropped;
        r.mism = totals[C_MISM]; r.tmo = totals[C_TMO]; r.refu = totals[C_REFU];
        r.repl = totals[C_REPL]; r.reqs = totals[C_REQS];
        expected_results.push_back(r);
    endfunction

    function automatic void close_request(bit refused);
        trk_pending = 0;
        rep_age = 0;
        trk_down = 0;
        bump(C_REPL);
        if (refused) bump(C_REFU);
    endfunction

    function automatic void mismatch();
        bump(C_MISM);
        emit(ST_MISMATCH, 0, 0, 1, 0);
    endfunction

    // apply one fragment to the collected window
    function automatic void predict_fragment(txn_t t);
        int wend, at, pos, n;
        bit is_data, is_ack, is_nack, ours;
        logic [15:0] words [4];
        logic [31:0] want;
        if (!trk_pending) begin
            mismatch();
            return;
        end
        is_data = (t.frag_op == FK_DATA) && !trk_write;
        is_ack  = (t.frag_op == FK_ACK) && trk_write;
        is_nack = (t.frag_op == FK_NACK);
        if ((!is_data && !is_ack && !is_nack) || t.page != trk_page) begin
            mismatch();
            return;
        end
        wend = int'(trk_off) + int'(trk_cnt);
        if (is_nack) begin
            if (!trk_write) ours = (int'(t.offset) == int'(trk_off));
            else if (t.offset < trk_off || int'(t.offset) >= wend) ours = 0;
            else ours = ((int'(t.offset) - int'(trk_off)) % FRAME_REGS_DEF) == 0;
            if (!ours) begin
                mismatch();
                return;
            end
            close_request(1);
            emit(ST_REFUSED, t.offset, t.wa, 1, 0);
            return;
        end
        if (t.count == 0 || t.count > FRAME_REGS_DEF || t.offset < trk_off
            || int'(t.offset) + int'(t.count) > wend) begin
            mismatch();
            return;
        end
        words[0] = t.wa; words[1] = t.wb; words[2] = t.wc; words[3] = t.wd;
        at = int'(t.offset) - int'(trk_off);
        for (int i = 0; i < int'(t.count); i++) begin
            pos = (at + i) & 31;
            trk_words[pos] = words[i];
            trk_seen[pos] = 1'b1;
        end
        want = (trk_cnt >= 32) ? 32'hFFFF_FFFF : ((32'd1 << trk_cnt) - 32'd1);
        if ((trk_seen & want) != want) begin
            emit(ST_PARTIAL, 0, 0, 1, 0);
            return;
        end
        close_request(0);
        n = int'(trk_cnt);
        for (int i = 0; i < n; i++)
            emit(trk_write ? ST_WR_DONE : ST_RD_DONE, i, trk_words[i], i == n - 1, 0);
    endfunction

    function automatic void predict_step(txn_t t);
        bit acted, dropped;
        case (t.func)
            FN_RD, FN_WR: begin
                if (trk_pending || t.count == 0 || t.count > WINDOW_REGS_DEF
                    || int'(t.offset) + int'(t.count) > WINDOW_REGS_DEF) begin
                    emit(ST_REJECTED, 0, 0, 1, 0);
                end else begin
                    trk_pending = 1;
                    trk_write = (t.func == FN_WR);
                    trk_page = t.page;
                    trk_off = t.offset[4:0];
                    trk_cnt = t.count[5:0];
                    trk_seen = 0;
                    req_age = 0;
                    bump(C_REQS);
                    emit(ST_STARTED, 0, 0, 1, 0);
                end
            end
            FN_FRAG: predict_fragment(t);
            FN_TICK: begin
                acted = 0;
                dropped = 0;
                if (req_age != 16'hFFFF) req_age++;
                if (rep_age != 16'hFFFF) rep_age++;
                if (trk_pending && req_age >= timeout_cfg) begin
                    trk_pending = 0;
                    bump(C_TMO);
                    acted = 1;
                    dropped = 1;
                end
                if (!trk_down && rep_age >= timeout_cfg) begin
                    trk_down = 1;
                    acted = 1;
                end
                emit(acted ? ST_TICK_ACT : ST_TICK_Q, 0, 0, 1, dropped);
            end
            FN_ABORT: begin
                if (trk_pending) begin
                    trk_pending = 0;
                    bump(C_TMO);
                    emit(ST_ABANDONED, 0, 0, 1, 0);
                end else begin
                    emit(ST_ABAND_IGN, 0, 0, 1, 0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // predict on accepted transactions, then check accepted results
    always @(posedge i_clk) begin
        res_t e;
        txn_t t;
        in_took <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                t.func = i_func; t.page = i_page; t.offset = i_offset;
                t.count = i_count; t.frag_op = i_frag_op;
                t.wa = i_word_a; t.wb = i_word_b; t.wc = i_word_c; t.wd = i_word_d;
                predict_step(t);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with status %0d but none expected", o_status);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", e.status, o_status);
                    check_field("word_index", e.idx, o_word_index);
                    check_field("word_value", e.value, o_word_value);
                    check_field("last", e.last, o_last);
                    check_field("busy_res", e.busy, o_busy_res);
                    check_field("link_down", e.down, o_link_down);
                    check_field("request_dropped", e.dropped, o_request_dropped);
                    check_field("mismatch_total", e.mism, o_mismatch_total);
                    check_field("timeout_total", e.tmo, o_timeout_total);
                    check_field("refusal_total", e.refu, o_refusal_total);
                    check_field("reply_total", e.repl, o_reply_total);
                    check_field("request_total", e.reqs, o_request_total);
                end
            end
        end
    end

    // drive the next transaction once the current one is taken
    always @(negedge i_clk) begin
        txn_t t;
        logic nv;
        if (run_en) begin
            if (i_in_valid && !in_took) begin
                nv = 1;
            end else if (send_gap > 0) begin
                send_gap--;
                nv = 0;
            end else if (pending_txns.size() > 0) begin
                t = pending_txns.pop_front();
                i_func <= t.func; i_page <= t.page; i_offset <= t.offset;
                i_count <= t.count; i_frag_op <= t.frag_op;
                i_word_a <= t.wa; i_word_b <= t.wb; i_word_c <= t.wc; i_word_d <= t.wd;
                nv = 1;
                send_gap = gap_len();
            end else begin
                nv = 0;
            end
            i_in_valid <= nv;
        end
    end

    // stall the result side, with a long hold-off on request
    always @(negedge i_clk) begin
        if (run_en) begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= 1;
                if ($urandom_range(0, 3) == 0) ready_gap = gap_len();
            end
        end
    end

    function automatic txn_t mk(logic [2:0] f, logic [7:0] pg, logic [7:0] off,
                                logic [7:0] cnt, logic [1:0] op,
                                logic [15:0] a, logic [15:0] b,
                                logic [15:0] c, logic [15:0] d);
        txn_t t;
        t.func = f; t.page = pg; t.offset = off; t.count = cnt; t.frag_op = op;
        t.wa = a; t.wb = b; t.wc = c; t.wd = d;
        return t;
    endfunction

    function automatic txn_t noise();
        return mk($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endfunction

    // one well-formed request with random fragmenting, ticks and faults
    task automatic add_request();
        bit wr;
        int cnt, off, pos, n, r;
        logic [7:0] pg;
        wr = $urandom_range(0, 1);
        pg = $urandom;
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        off = $urandom_range(0, 32 - cnt);
        pending_txns.push_back(mk(wr ? FN_WR : FN_RD, pg, off, cnt, 0, 0, 0, 0, 0));
        pos = 0;
        while (pos < cnt) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                pending_txns.push_back(mk(FN_FRAG, pg, wr ? off + (pos & ~3) : off,
                                          $urandom, FK_NACK, $urandom, $urandom,
                                          $urandom, $urandom));
                return;
            end else if (r < 8) begin
                pending_txns.push_back(mk(FN_ABORT, 0, 0, 0, 0, 0, 0, 0, 0));
                return;
            end else if (r < 18) begin
                pending_txns.push_back(mk(FN_TICK, $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom));
            end else if (r < 24) begin
                pending_txns.push_back(noise());
            end
            n = $urandom_range(1, 4);
            if (n > cnt - pos) n = cnt - pos;
            pending_txns.push_back(mk(FN_FRAG, pg, off + pos, n, wr ? FK_ACK : FK_DATA,
                                      $urandom, $urandom, $urandom, $urandom));
            // resend the same positions now and then
            if ($urandom_range(0, 9) != 0) pos += n;
        end
    endtask

    task automatic add_random(int n_items);
        int goal, r, k;
        goal = pending_txns.size() + n_items;
        while (pending_txns.size() < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_request();
            end else if (r < 85) begin
                k = $urandom_range(1, 5);
                repeat (k) pending_txns.push_back(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
            end else begin
                pending_txns.push_back(noise());
            end
        end
    endtask

    task automatic drain();
        while (!(pending_txns.size() == 0 && !i_in_valid && expected_results.size() == 0))
            @(posedge i_clk);
        // let any resultless transaction finish
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_TIMEOUT; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        timeout_cfg = v;
    endtask

    initial begin
        #40_000_000;
        $display("fragmented_register_transaction_tracker_unit_tb: errors");
        $finish;
    end

    initial begin
        trk_pending = 0; trk_write = 0; trk_down = 0; trk_page = 0; trk_off = 0;
        trk_cnt = 0; trk_seen = 0; req_age = 0; rep_age = 0;
        timeout_cfg = TIMEOUT_RESET;
        for (int i = 0; i < 5; i++) totals[i] = 0;
        for (int i = 0; i < 32; i++) trk_words[i] = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        run_en = 1;

        // directed: idle cases, bad starts, invalid functions, bad fragments, refusals, completions
        pending_txns.push_back(mk(FN_FRAG, 0, 0, 1, FK_DATA, 1, 2, 3, 4));
        pending_txns.push_back(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_ABORT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_RD, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_RD, 0, 31, 2, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_WR, 0, 0, 33, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(3'd5, 8'hFF, 8'hFF, 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF));
        pending_txns.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_RD, 8'hFF, 0, 32, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_RD, 8'hFF, 0, 1, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFE, 0, 4, FK_DATA, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 0, 4, FK_ACK, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 0, 4, FK_OTHER, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 0, 0, FK_DATA, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 0, 5, FK_DATA, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 30, 4, FK_DATA, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 8'hFF, 4, 4, FK_NACK, 0, 0, 0, 0));
        for (int i = 0; i < 32; i += 4)
            pending_txns.push_back(mk(FN_FRAG, 8'hFF, i, 4, FK_DATA, 16'h0000, 16'hFFFF,
                                      i, 16'hA5A5));
        pending_txns.push_back(mk(FN_WR, 0, 28, 4, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 0, 28, 0, FK_NACK, 16'h1234, 0, 0, 0));
        pending_txns.push_back(mk(FN_WR, 0, 0, 8, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 0, 2, 1, FK_NACK, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_FRAG, 0, 0, 4, FK_ACK, 1, 2, 3, 4));
        pending_txns.push_back(mk(FN_FRAG, 0, 0, 4, FK_ACK, 5, 6, 7, 8));
        pending_txns.push_back(mk(FN_FRAG, 0, 4, 4, FK_ACK, 9, 10, 11, 12));
        pending_txns.push_back(mk(FN_RD, 3, 5, 3, 0, 0, 0, 0, 0));
        pending_txns.push_back(mk(FN_ABORT, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // short, long and zero timeouts, with a long result-side hold-off in the first and last runs
        write_timeout(16'd3);
        hold_token++;
        add_random(100);
        drain();
        write_timeout(16'd1);
        calm = 1;
        add_random(60);
        drain();
        calm = 0;
        write_timeout(16'hFFFF);
        add_random(80);
        drain();
        write_timeout(16'd0);
        add_random(30);
        drain();
        write_timeout(TIMEOUT_RESET);
        hold_token++;
        add_random(80);
        drain();

        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fails++;
        end
        if (fails == 0) begin
            $display("fragmented_register_transaction_tracker_unit_tb: clean");
        end else begin
            $display("fragmented_register_transaction_tracker_unit_tb: errors");
        end
        $finish;
    end

endmodule
